>>> src/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared types, codes and helper functions for the LVDS bitslip lane aligner.
// ----------------------------------------------------------------------------
package lba_pkg;

    localparam int DATA_LANES = 4;   // 1..4
    localparam int IMAGERS    = 2;   // 1..2

    localparam logic [2:0] LAST_LANE = 3'(DATA_LANES);

    localparam logic [9:0] MAX_ATTEMPTS_RST  = 10'd1000;
    localparam logic [7:0] TRAINING_WORD_RST = 8'd233;
    localparam logic [9:0] SLIP_CNT_MAX      = 10'd1023;

    localparam int SYNC_SHIFT  = 24;
    localparam int DATA_SHIFT  = 16;
    localparam int SYNC_BIT    = 4;
    localparam int LANE_STRIDE = 5;

    typedef enum logic {
        FN_START  = 1'b0,
        FN_SAMPLE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2,
        ST_IDLE = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MAX_ATTEMPTS  = 1'b0,
        CFG_TRAINING_WORD = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        func;
        logic        imager;
        logic [31:0] sample_word;
    } t_in;

    typedef struct packed {
        logic [9:0] slip_mask;
        logic [2:0] next_channel;
        logic [1:0] status;
        logic [2:0] lane;
        logic [9:0] slip_count;
    } t_out;

    typedef struct packed {
        logic       busy;
        logic       imager;
        logic [2:0] lane;
        logic [9:0] attempts;
        logic [9:0] slips;
    } t_state;

    // channel carrying a lane: imager*4, plus data lane index less one (sync lane 0 adds nothing)
    function automatic logic [2:0] chan_of(input logic img, input logic [2:0] lane);
        logic [2:0] ch;
        ch = {img, 2'b00};
        if (lane != 3'd0) begin
            ch = ch + (lane - 3'd1);
        end
        return ch;
    endfunction

    function automatic logic [9:0] slip_bit(input logic img, input logic [2:0] lane);
        logic [3:0] pos;
        pos = (lane == 3'd0) ? 4'(SYNC_BIT) : ({1'b0, lane} - 4'd1);
        pos = pos + (img ? 4'(LANE_STRIDE) : 4'd0);
        return 10'd1 << pos;
    endfunction

    function automatic logic sync_match(input logic [7:0] b);
        return (b == 8'h0d) || (b == 8'h0a) || (b == 8'he9) || (b == 8'haa) ||
               (b == 8'hca) || (b == 8'h4a) || (b == 8'h16) || (b == 8'h05);
    endfunction

endpackage

>>> src/lba_step.sv
// ----------------------------------------------------------------------------
// lba_step
// Next state and result for one beat: lane compare, slip request and the
// attempt / slip counter updates.
// ----------------------------------------------------------------------------
module lba_step (
    input  lba_pkg::t_in    i_item,
    input  lba_pkg::t_state i_st,
    input  logic [9:0]      i_max_attempts,
    input  logic [7:0]      i_training_word,
    output lba_pkg::t_state o_st,
    output lba_pkg::t_out   o_res
);

    logic [7:0] sync_byte;
    logic [7:0] data_byte;
    logic       hit;
    logic       slip;
    logic [9:0] att_inc;
    logic [9:0] slips_inc;
    logic [9:0] mask;

    assign sync_byte = i_item.sample_word[lba_pkg::SYNC_SHIFT +: 8];
    assign data_byte = i_item.sample_word[lba_pkg::DATA_SHIFT +: 8];
    assign att_inc   = i_st.attempts + 10'd1;

    always_comb begin
        if (i_st.lane == 3'd0) begin
            hit  = lba_pkg::sync_match(sync_byte);
            slip = !hit && (sync_byte != 8'd0);
        end else begin
            hit  = (data_byte == i_training_word);
            slip = !hit;
        end
        slips_inc = (slip && (i_st.slips != lba_pkg::SLIP_CNT_MAX)) ?
                    i_st.slips + 10'd1 : i_st.slips;
        mask      = slip ? lba_pkg::slip_bit(i_st.imager, i_st.lane) : 10'd0;
    end

    always_comb begin
        o_st  = i_st;
        o_res = '0;
        if (i_item.func == lba_pkg::FN_START) begin
            o_st.attempts = '0;
            o_st.slips    = '0;
            o_st.lane     = '0;
            if (int'(i_item.imager) >= lba_pkg::IMAGERS) begin
                o_st.busy    = 1'b0;
                o_st.imager  = 1'b0;
                o_res.status = lba_pkg::ST_FAIL;
            end else begin
                o_st.busy          = 1'b1;
                o_st.imager        = i_item.imager;
                o_res.next_channel = lba_pkg::chan_of(i_item.imager, 3'd0);
                o_res.status       = lba_pkg::ST_BUSY;
            end
        end else if (!i_st.busy) begin
            o_res.status = lba_pkg::ST_IDLE;
        end else if (hit) begin
            o_st.attempts = '0;
            o_st.slips    = '0;
            if (i_st.lane >= lba_pkg::LAST_LANE) begin
                o_st.busy          = 1'b0;
                o_st.lane          = '0;
                o_res.next_channel = lba_pkg::chan_of(i_st.imager, 3'd0);
                o_res.status       = lba_pkg::ST_DONE;
                o_res.lane         = lba_pkg::LAST_LANE;
                o_res.slip_count   = i_st.slips;
            end else begin
                o_st.lane          = i_st.lane + 3'd1;
                o_res.next_channel = lba_pkg::chan_of(i_st.imager, i_st.lane + 3'd1);
                o_res.status       = lba_pkg::ST_BUSY;
                o_res.lane         = i_st.lane + 3'd1;
            end
        end else begin
            o_res.slip_mask    = mask;
            o_res.next_channel = lba_pkg::chan_of(i_st.imager, i_st.lane);
            o_res.lane         = i_st.lane;
            o_res.slip_count   = slips_inc;
            // zero max_attempts fails on the first sample too
            if (att_inc >= i_max_attempts) begin
                o_st.busy     = 1'b0;
                o_st.lane     = '0;
                o_st.attempts = '0;
                o_st.slips    = '0;
                o_res.status  = lba_pkg::ST_FAIL;
            end else begin
                o_st.attempts = att_inc;
                o_st.slips    = slips_inc;
                o_res.status  = lba_pkg::ST_BUSY;
            end
        end
    end

endmodule

>>> src/lvds_bitslip_lane_aligner_unit.sv
// ----------------------------------------------------------------------------
// lvds_bitslip_lane_aligner_unit
// Bitslip word alignment of the sync and data lanes of one imager at a time.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                           | beat
//  ---------+-----------+-----------------------------------+---------------------
//  in       | sink      | i_in_valid / o_in_ready / i_in    | start or sample word
//  out      | source    | o_out_valid / i_out_ready / o_out | one result per beat
//  cfg      | sink      | i_cfg_we / i_cfg_idx / i_cfg_data | register write
//
//  One beat per cycle sustained while results are taken. A taken beat goes
//  to the input register, then past the compare/count to the result register.
//  The alignment state updates as a beat moves from input to result register.
//  Synchronous active-low reset returns to idle with default registers.
//  A stalled result holds both stages; each stage refills as it drains.
// ----------------------------------------------------------------------------
module lvds_bitslip_lane_aligner_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lba_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lba_pkg::t_out  o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [9:0]     i_cfg_data
);

    logic            r_in_valid;
    lba_pkg::t_in    r_in;
    logic            r_out_valid;
    lba_pkg::t_out   r_out;
    lba_pkg::t_state r_st;
    lba_pkg::t_state n_st;
    lba_pkg::t_out   n_out;
    logic [9:0]      r_max_attempts;
    logic [7:0]      r_training_word;
    logic            advance;

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lba_step u_step (
        .i_item          (r_in),
        .i_st            (r_st),
        .i_max_attempts  (r_max_attempts),
        .i_training_word (r_training_word),
        .o_st            (n_st),
        .o_res           (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts  <= lba_pkg::MAX_ATTEMPTS_RST;
            r_training_word <= lba_pkg::TRAINING_WORD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lba_pkg::CFG_MAX_ATTEMPTS:  r_max_attempts  <= i_cfg_data;
                lba_pkg::CFG_TRAINING_WORD: r_training_word <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_st <= n_st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

>>> src/lba_checker.sv
// ----------------------------------------------------------------------------
// lba_checker
// Port-level checks on the lane aligner's result channel.
// ----------------------------------------------------------------------------
module lba_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input lba_pkg::t_out o_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out.slip_mask))
        else $error("slip mask not one-hot");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == lba_pkg::ST_IDLE |->
            o_out.slip_mask == '0 && o_out.next_channel == '0 &&
            o_out.lane == '0 && o_out.slip_count == '0)
        else $error("idle result carries data");

    a_done_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == lba_pkg::ST_DONE |->
            o_out.lane == lba_pkg::LAST_LANE && o_out.slip_mask == '0)
        else $error("done result on wrong lane or with slip");

endmodule

bind lvds_bitslip_lane_aligner_unit lba_checker u_lba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> tb/lvds_bitslip_lane_aligner_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lvds_bitslip_lane_aligner_unit_test
// Drives start and sample beats into the lane aligner under random stalls on
// both sides and checks every result beat against a local model of the
// sync/data lane alignment, attempt limit and slip counting.
// ----------------------------------------------------------------------------
module lvds_bitslip_lane_aligner_unit_test;

    localparam logic [7:0] SYNC_WORDS [8] = '{
        8'h0d, 8'h0a, 8'he9, 8'haa, 8'hca, 8'h4a, 8'h16, 8'h05
    };

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           in_valid   = 1'b0;
    lba_pkg::t_in   in_beat    = '0;
    logic           recv_ready = 1'b0;
    logic           cfg_we     = 1'b0;
    logic           cfg_idx    = 1'b0;
    logic [9:0]     cfg_data   = '0;
    logic           o_in_ready;
    logic           o_out_valid;
    lba_pkg::t_out  o_out;

    // aligner model: configuration and lane state
    logic [9:0] max_tries  = lba_pkg::MAX_ATTEMPTS_RST;
    logic [7:0] train_word = lba_pkg::TRAINING_WORD_RST;
    logic       busy_q     = 1'b0;
    logic       img_q      = 1'b0;
    logic [2:0] lane_q     = '0;
    logic [9:0] tries_q    = '0;
    logic [9:0] slips_q    = '0;

    lba_pkg::t_out exp_results[$];
    int   errors     = 0;
    int   live_beats = 0;
    int   send_idle  = 17;
    int   recv_idle  = 58;

    lvds_bitslip_lane_aligner_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (recv_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("lvds_bitslip_lane_aligner_unit: mismatch");
        $finish;
    end

    always @(negedge i_clk) begin
        recv_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    function automatic logic [2:0] lane_channel(input logic [2:0] lane);
        logic [2:0] ch;
        ch = {img_q, 2'b00};
        if (lane != 3'd0) begin
            ch = ch + lane - 3'd1;
        end
        return ch;
    endfunction

    function automatic logic [9:0] lane_slip_bit(input logic [2:0] lane);
        int pos;
        pos = (lane == 3'd0) ? 4 : int'(lane) - 1;
        pos = pos + (img_q ? 5 : 0);
        return 10'd1 << pos;
    endfunction

    function automatic logic is_sync_word(input logic [7:0] b);
        foreach (SYNC_WORDS[i]) begin
            if (SYNC_WORDS[i] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advances the model by one beat and returns the result it should cause
    function automatic lba_pkg::t_out predict_result(input lba_pkg::t_in beat);
        lba_pkg::t_out r;
        logic [7:0]    b;
        logic          hit;
        logic          slip;
        logic [2:0]    lane;
        r = '0;
        if (beat.func == lba_pkg::FN_START) begin
            tries_q = '0;
            slips_q = '0;
            lane_q  = '0;
            if (int'(beat.imager) >= lba_pkg::IMAGERS) begin
                busy_q   = 1'b0;
                img_q    = 1'b0;
                r.status = lba_pkg::ST_FAIL;
                return r;
            end
            busy_q = 1'b1;
            img_q  = beat.imager;
            r.next_channel = lane_channel(3'd0);
            r.status       = lba_pkg::ST_BUSY;
            return r;
        end
        if (!busy_q) begin
            r.status = lba_pkg::ST_IDLE;
            return r;
        end
        lane = lane_q;
        if (lane == 3'd0) begin
            b    = beat.sample_word[31:24];
            hit  = is_sync_word(b);
            slip = !hit && (b != 8'h00);
        end else begin
            b    = beat.sample_word[23:16];
            hit  = (b == train_word);
            slip = !hit;
        end
        tries_q = tries_q + 10'd1;
        if (hit) begin
            r.slip_count = slips_q;
            tries_q = '0;
            slips_q = '0;
            if (int'(lane) >= lba_pkg::DATA_LANES) begin
                busy_q = 1'b0;
                lane_q = '0;
                r.next_channel = lane_channel(3'd0);
                r.status       = lba_pkg::ST_DONE;
                r.lane         = 3'(lba_pkg::DATA_LANES);
                return r;
            end
            lane_q = lane + 3'd1;
            r.slip_count   = '0;
            r.next_channel = lane_channel(lane_q);
            r.status       = lba_pkg::ST_BUSY;
            r.lane         = lane_q;
            return r;
        end
        if (slip) begin
            r.slip_mask = lane_slip_bit(lane);
            if (slips_q < lba_pkg::SLIP_CNT_MAX) begin
                slips_q = slips_q + 10'd1;
            end
        end
        r.next_channel = lane_channel(lane);
        r.lane         = lane;
        r.slip_count   = slips_q;
        r.status       = lba_pkg::ST_BUSY;
        // zero limit behaves as one since the count is at least one here
        if (tries_q >= max_tries) begin
            r.status = lba_pkg::ST_FAIL;
            busy_q  = 1'b0;
            lane_q  = '0;
            tries_q = '0;
            slips_q = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        lba_pkg::t_out want;
        if (i_rst_n && o_out_valid && recv_ready) begin
            if (exp_results.size() == 0) begin
                report_mismatch("result beat with none pending", 32'(o_out), 32'd0);
            end else begin
                want = exp_results.pop_front();
                if (o_out.slip_mask !== want.slip_mask)
                    report_mismatch("slip_mask", 32'(o_out.slip_mask),
                                    32'(want.slip_mask));
                if (o_out.next_channel !== want.next_channel)
                    report_mismatch("next_channel", 32'(o_out.next_channel),
                                    32'(want.next_channel));
                if (o_out.status !== want.status)
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                if (o_out.lane !== want.lane)
                    report_mismatch("lane", 32'(o_out.lane), 32'(want.lane));
                if (o_out.slip_count !== want.slip_count)
                    report_mismatch("slip_count", 32'(o_out.slip_count),
                                    32'(want.slip_count));
            end
        end
    end

    // entered and left at a falling edge; valid is left high after the beat
    task automatic send_beat(input lba_pkg::t_in beat);
        lba_pkg::t_out r;
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_beat  = beat;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        r = predict_result(beat);
        exp_results.insert(exp_results.size(), r);
        if (r.status != lba_pkg::ST_IDLE) begin
            live_beats++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_start(input logic img);
        lba_pkg::t_in b;
        b.func        = lba_pkg::FN_START;
        b.imager      = img;
        b.sample_word = $urandom;
        send_beat(b);
    endtask

    task automatic send_sample(input logic [31:0] word);
        lba_pkg::t_in b;
        b.func        = lba_pkg::FN_SAMPLE;
        b.imager      = 1'($urandom);
        b.sample_word = word;
        send_beat(b);
    endtask

    task automatic wait_drain();
        int n;
        n = 0;
        in_valid = 1'b0;
        while (exp_results.size() != 0 && n < 50000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input lba_pkg::t_cfg_idx idx, input logic [9:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        if (idx == lba_pkg::CFG_MAX_ATTEMPTS) begin
            max_tries = value;
        end else begin
            train_word = value[7:0];
        end
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_idle_samples();
        send_sample(32'h0000_0000);
        send_sample(32'hffff_ffff);
    endtask

    // full pass on imager 1 with reset defaults, one slip on sync and data lanes 1, 4
    task automatic test_full_alignment();
        send_start(1'b1);
        send_sample({8'h00, 24'h5a5a5a});
        send_sample({8'hff, 24'ha5a5a5});
        send_sample({8'h05, 24'h000000});
        send_sample({8'hff, 8'h00, 16'hffff});
        send_sample({8'h00, lba_pkg::TRAINING_WORD_RST, 16'h0000});
        send_sample({8'h12, lba_pkg::TRAINING_WORD_RST, 16'h3456});
        send_sample({8'hed, lba_pkg::TRAINING_WORD_RST, 16'hcba9});
        send_sample({8'h00, 8'hff, 16'h0000});
        send_sample({8'hff, lba_pkg::TRAINING_WORD_RST, 16'hffff});
    endtask

    task automatic test_restart();
        send_start(1'b0);
        send_sample({8'h0d, 24'h123456});
        send_start(1'b0);
        send_sample({8'haa, 24'h654321});
        send_start(1'b1);
    endtask

    task automatic test_lane_fail();
        wait_drain();
        write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'd2);
        send_start(1'b0);
        send_sample({8'h11, 24'h0});
        // zero sync byte on the final attempt: fail without a slip
        send_sample({8'h00, 24'hffffff});
        wait_drain();
        write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'd0);
        send_start(1'b1);
        send_sample({8'h33, 24'h0});
        wait_drain();
        write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'd1);
        send_start(1'b1);
        send_sample({8'h0a, 24'h0});
        send_sample({8'h00, ~lba_pkg::TRAINING_WORD_RST, 16'h0});
    endtask

    // start, then samples aimed at the current lane until done, failed or cut off
    task automatic run_alignment(input logic img, input int hit_pct, input int cut);
        logic [31:0] w;
        int          n;
        send_start(img);
        n = 0;
        while (busy_q && n < cut) begin
            w = $urandom;
            if (lane_q == 3'd0) begin
                if ($urandom_range(0, 99) < hit_pct)
                    w[31:24] = SYNC_WORDS[$urandom_range(0, 7)];
                else if ($urandom_range(0, 3) == 0)
                    w[31:24] = 8'h00;
            end else if ($urandom_range(0, 99) < hit_pct) begin
                w[23:16] = train_word;
            end
            send_sample(w);
            n++;
        end
    endtask

    task automatic test_random_phases();
        int            first;
        lba_pkg::t_in  b;
        for (int chunk = 0; chunk < 6; chunk++) begin
            wait_drain();
            case (chunk / 2)
                0: begin send_idle = 17; recv_idle = 58; end
                1: begin send_idle = 58; recv_idle = 17; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (chunk % 3)
                0: write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'd1023);
                1: write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'($urandom_range(1, 3)));
                default: write_reg(lba_pkg::CFG_MAX_ATTEMPTS, 10'($urandom_range(4, 60)));
            endcase
            case (chunk)
                0: write_reg(lba_pkg::CFG_TRAINING_WORD, {2'($urandom), 8'h00});
                1: write_reg(lba_pkg::CFG_TRAINING_WORD, {2'($urandom), 8'hff});
                default: write_reg(lba_pkg::CFG_TRAINING_WORD, 10'($urandom));
            endcase
            first = live_beats;
            while (live_beats - first < 90) begin
                if ($urandom_range(0, 99) < 85) begin
                    run_alignment(1'($urandom), $urandom_range(5, 70),
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 4000);
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        b.func        = 1'($urandom);
                        b.imager      = 1'($urandom);
                        b.sample_word = $urandom;
                        send_beat(b);
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_idle_samples();
        test_full_alignment();
        test_restart();
        test_lane_fail();
        test_random_phases();
        wait_drain();
        if (exp_results.size() != 0) begin
            report_mismatch("result beats never arrived", 32'(exp_results.size()), 32'd0);
        end
        if (errors == 0) begin
            $display("lvds_bitslip_lane_aligner_unit: match");
        end else begin
            $display("lvds_bitslip_lane_aligner_unit: mismatch");
        end
        $finish;
    end

endmodule

>>> lvds_bitslip_lane_aligner_unit.f
src/lba_pkg.sv
src/lba_step.sv
src/lvds_bitslip_lane_aligner_unit.sv
src/lba_checker.sv
tb/lvds_bitslip_lane_aligner_unit_test.sv
